>>> rtl/yuvrgb_pkg.sv
// Shared types, coefficients and channel clamp for the 4:2:0 block to RGB888 converter.
// No dependencies.
package yuvrgb_pkg;

    localparam int FRAC_BITS = 13;
    localparam int SUM_W     = 24;
    localparam int PROD_Y_W  = 22;
    localparam int LANES     = 4;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 96;

    localparam logic        [13:0] COEF_Y  = 14'd9535;
    localparam logic signed [15:0] COEF_RV = 16'sd13074;
    localparam logic signed [15:0] COEF_GV = 16'sd6660;
    localparam logic signed [15:0] COEF_GU = 16'sd3203;
    localparam logic signed [15:0] COEF_BU = 16'sd16531;
    localparam logic        [7:0]  CHAN_MAX = 8'd255;

    // Chroma contributions shared by all four pixels of a block
    typedef struct packed {
        logic signed [SUM_W-1:0] red_term;
        logic signed [SUM_W-1:0] green_term;
        logic signed [SUM_W-1:0] blue_term;
    } chroma_terms_t;

    // Floor shift by FRAC_BITS, then clamp to 0..255
    function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
        logic [SUM_W-FRAC_BITS-1:0] q;
        q = sum[SUM_W-1:FRAC_BITS];
        if (q[SUM_W-FRAC_BITS-1])
            return 8'd0;
        else if (|q[SUM_W-FRAC_BITS-2:8])
            return CHAN_MAX;
        else
            return q[7:0];
    endfunction

endpackage

>>> rtl/yuv420_block_to_rgb.sv
// Throughput: one 2x2 block per cycle unless m_tready stalls the output; stage 1 holds the luma
// and shared chroma products, stage 2 the merged output register.
// Each stage advances when it is empty or the stage after it moves; a stall holds stage 2, and stage 1 once full.
// Reset (rst_n low, asynchronous) clears both stage valid flags; data registers keep values.
// Depends on yuvrgb_pkg, yuvrgb_chroma and yuvrgb_lane.
module yuv420_block_to_rgb
    import yuvrgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // chroma_blue, chroma_red (8 bits each, from bit 0 up)
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // rgb_top_left, rgb_top_right, rgb_bottom_left, rgb_bottom_right (24 bits each, from bit 0 up)
    output logic [OUT_W-1:0] m_tdata
);

    logic               valid1_reg;
    logic               valid1_next;
    logic               valid2_reg;
    logic               valid2_next;
    logic [OUT_W-1:0]   data2_reg;
    logic [OUT_W-1:0]   data2_next;
    logic               adv1;
    logic               adv2;
    chroma_terms_t      terms;
    logic [LANES*24-1:0] lane_rgb;

    assign adv2     = !valid2_reg || m_tready;
    assign adv1     = !valid1_reg || adv2;
    assign s_tready = adv1;

    yuvrgb_chroma u_chroma (
        .clk         (clk),
        .en          (adv1),
        .chroma_blue (s_tdata[39:32]),
        .chroma_red  (s_tdata[47:40]),
        .terms       (terms)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        yuvrgb_lane u_lane (
            .clk   (clk),
            .en    (adv1),
            .luma  (s_tdata[i*8 +: 8]),
            .terms (terms),
            .rgb   (lane_rgb[i*24 +: 24])
        );
    end

    always_comb
    begin
        valid1_next = adv1 ? s_tvalid : valid1_reg;
        valid2_next = adv2 ? valid1_reg : valid2_reg;
        data2_next  = adv2 ? lane_rgb : data2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data2_reg <= data2_next;
    end

    assign m_tvalid = valid2_reg;
    assign m_tdata  = data2_reg;

`ifndef ASSERT_OFF
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output stage is empty");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid1_reg && !adv2) |=> valid1_reg)
        else $error("stage 1 block dropped during stall");

    a_stage1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (valid1_reg && adv2) |=> m_tvalid)
        else $error("stage 1 block did not reach output");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid1_reg)
        else $error("input transfer not captured in stage 1");
`endif

endmodule

>>> rtl/yuvrgb_chroma.sv
// Shared chroma stage: centers U and V and registers their scaled terms.
// Depends on yuvrgb_pkg.
module yuvrgb_chroma
    import yuvrgb_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [7:0]    chroma_blue,
    input  logic [7:0]    chroma_red,
    output chroma_terms_t terms
);

    logic signed [7:0] du;
    logic signed [7:0] dv;
    chroma_terms_t     terms_reg;
    chroma_terms_t     terms_next;

    // value - 128 is the byte with its top bit flipped, read as signed
    assign du = signed'({~chroma_blue[7], chroma_blue[6:0]});
    assign dv = signed'({~chroma_red[7], chroma_red[6:0]});

    always_comb
    begin
        terms_next.red_term   = SUM_W'(COEF_RV) * SUM_W'(dv);
        terms_next.green_term = SUM_W'(COEF_GV) * SUM_W'(dv) + SUM_W'(COEF_GU) * SUM_W'(du);
        terms_next.blue_term  = SUM_W'(COEF_BU) * SUM_W'(du);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            terms_reg <= terms_next;
    end

    assign terms = terms_reg;

endmodule

>>> rtl/yuvrgb_lane.sv
// One pixel lane: registers the luma product, then sums, floors, clamps and packs.
// Depends on yuvrgb_pkg.
module yuvrgb_lane
    import yuvrgb_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [7:0]    luma,
    input  chroma_terms_t terms,
    output logic [23:0]   rgb
);

    logic [PROD_Y_W-1:0]     y_prod_reg;
    logic [PROD_Y_W-1:0]     y_prod_next;
    logic signed [SUM_W-1:0] y_term;
    logic signed [SUM_W-1:0] red_sum;
    logic signed [SUM_W-1:0] green_sum;
    logic signed [SUM_W-1:0] blue_sum;

    assign y_prod_next = {{(PROD_Y_W-14){1'b0}}, COEF_Y} * {{(PROD_Y_W-8){1'b0}}, luma};

    always_ff @(posedge clk)
    begin
        if (en)
            y_prod_reg <= y_prod_next;
    end

    assign y_term    = signed'({{(SUM_W-PROD_Y_W){1'b0}}, y_prod_reg});
    assign red_sum   = y_term + terms.red_term;
    assign green_sum = y_term - terms.green_term;
    assign blue_sum  = y_term + terms.blue_term;

    assign rgb = {clamp_channel(red_sum), clamp_channel(green_sum), clamp_channel(blue_sum)};

endmodule

>>> tb/tb.sv
// Self-checking testbench for yuv420_block_to_rgb: 2x2 4:2:0 blocks go in, four RGB888 pixels out.
// Drives directed and random blocks with random idling on both stream sides.
// Depends on yuvrgb_pkg and the yuv420_block_to_rgb RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import yuvrgb_pkg::*;

    localparam int Y_GAIN       = 9535;
    localparam int RV_GAIN      = 13074;
    localparam int GV_GAIN      = 6660;
    localparam int GU_GAIN      = 3203;
    localparam int BU_GAIN      = 16531;
    localparam int CHROMA_MID   = 128;
    localparam int RANDOM_BLOCKS = 2000;
    localparam int MAX_GAP      = 13;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_DIRECTED = 20;

    typedef struct packed {
        logic [7:0]       luma_tl;
        logic [7:0]       luma_tr;
        logic [7:0]       luma_bl;
        logic [7:0]       luma_br;
        logic [7:0]       chroma_u;
        logic [7:0]       chroma_v;
        logic             typed_in;
        logic [OUT_W-1:0] rgb;
    } test_block_t;

    // Rows with typed_in set carry a value read straight off the formulas
    test_block_t directed_blocks [NUM_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128, 1'b1, {4{24'h000000}}},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128, 1'b1, {4{24'hFFFFFF}}},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, {4{24'h009A00}}},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, {4{24'hFF8FFF}}},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 1'b1, {4{24'hCA00FF}}},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   1'b1, {4{24'h5CFF26}}},
        '{8'd1,   8'd1,   8'd1,   8'd1,   8'd128, 8'd128, 1'b1, {4{24'h010101}}},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   1'b0, '0},
        '{8'd16,  8'd100, 8'd180, 8'd235, 8'd128, 8'd128, 1'b0, '0},
        '{8'd0,   8'd85,  8'd170, 8'd255, 8'd90,  8'd200, 1'b0, '0},
        // small negative sums must floor to -1 and clamp, not truncate to 0
        '{8'd1,   8'd1,   8'd1,   8'd1,   8'd128, 8'd127, 1'b0, '0},
        '{8'd0,   8'd1,   8'd2,   8'd3,   8'd129, 8'd127, 1'b0, '0},
        '{8'h55,  8'h55,  8'h55,  8'h55,  8'h55,  8'h55,  1'b0, '0},
        '{8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  1'b0, '0},
        '{8'h01,  8'h02,  8'h04,  8'h08,  8'h10,  8'h20,  1'b0, '0},
        '{8'h80,  8'h40,  8'h20,  8'h10,  8'h08,  8'h04,  1'b0, '0},
        // luma around the point where a channel first saturates
        '{8'd219, 8'd220, 8'd200, 8'd60,  8'd128, 8'd128, 1'b0, '0},
        '{8'd40,  8'd200, 8'd120, 8'd250, 8'd60,  8'd190, 1'b0, '0},
        '{8'd128, 8'd64,  8'd32,  8'd250, 8'd255, 8'd0,   1'b0, '0}
    };

    string lane_names [LANES] = '{"rgb_top_left", "rgb_top_right",
                                  "rgb_bottom_left", "rgb_bottom_right"};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    logic [OUT_W-1:0] rgb_blocks_due [$];
    int               mismatch_count;
    int               blocks_sent;
    int               blocks_taken;
    int               quiet_cycles;

    yuv420_block_to_rgb u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor shift, then clamp to one byte
    function automatic logic [7:0] clamp_floor(input int sum);
        int level;
        level = sum >>> FRAC_BITS;
        if (level < 0)
            return 8'd0;
        if (level > 255)
            return 8'hFF;
        return level[7:0];
    endfunction

    function automatic logic [23:0] convert_pixel(input logic [7:0] luma, input int du,
                                                  input int dv);
        int y;
        y = int'(luma);
        return {clamp_floor(Y_GAIN * y + RV_GAIN * dv),
                clamp_floor(Y_GAIN * y - GV_GAIN * dv - GU_GAIN * du),
                clamp_floor(Y_GAIN * y + BU_GAIN * du)};
    endfunction

    function automatic logic [OUT_W-1:0] convert_block(input logic [IN_W-1:0] blk);
        logic [OUT_W-1:0] rgb;
        int               du;
        int               dv;
        du = int'(blk[39:32]);
        du = du - CHROMA_MID;
        dv = int'(blk[47:40]);
        dv = dv - CHROMA_MID;
        for (int k = 0; k < LANES; k++)
            rgb[k*24 +: 24] = convert_pixel(blk[k*8 +: 8], du, dv);
        return rgb;
    endfunction

    // Bias random samples toward the ends and the chroma center
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd128;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_block(input logic [IN_W-1:0] blk, input logic [OUT_W-1:0] rgb);
        int gap;
        // every third stretch of 100 blocks runs back to back
        gap = ((blocks_sent / 100) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        do @(posedge clk); while (!s_tready);
        rgb_blocks_due.push_back(rgb);
        blocks_sent++;
    endtask

    task automatic check_block(input logic [OUT_W-1:0] got);
        logic [OUT_W-1:0] want;
        if (rgb_blocks_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: unexpected output transfer %h", $realtime, got);
            return;
        end
        want = rgb_blocks_due.pop_front();
        for (int k = 0; k < LANES; k++)
        begin
            if (got[k*24 +: 24] !== want[k*24 +: 24])
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: %s expected %h, got %h", $realtime, lane_names[k],
                             want[k*24 +: 24], got[k*24 +: 24]);
            end
        end
    endtask

    // Output side: random stall ahead of each transfer, with stall-free stretches
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = ((blocks_taken / 120) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            blocks_taken++;
            check_block(m_tdata);
        end
    end

    // Watchdog: end the run when neither side has moved for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** yuv420_block_to_rgb: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [IN_W-1:0] blk;
        test_block_t     row;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        blocks_sent    = 0;
        blocks_taken   = 0;
        quiet_cycles   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_blocks[i])
        begin
            row = directed_blocks[i];
            blk = {row.chroma_v, row.chroma_u, row.luma_br, row.luma_bl,
                   row.luma_tr, row.luma_tl};
            send_block(blk, row.typed_in ? row.rgb : convert_block(blk));
        end

        for (int i = 0; i < RANDOM_BLOCKS; i++)
        begin
            blk = {pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                   pick_sample(), pick_sample()};
            send_block(blk, convert_block(blk));
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rgb_blocks_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** yuv420_block_to_rgb: PASSED **");
        else
            $display("** yuv420_block_to_rgb: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/yuvrgb_pkg.sv
rtl/yuvrgb_chroma.sv
rtl/yuvrgb_lane.sv
rtl/yuv420_block_to_rgb.sv
tb/tb.sv
